>>> rtl/ebec_pkg.sv
// ============================================================================
// ebec_pkg - shared types and constants of the encoder/button edit controller
// Configuration, state and result structures, event and register codes.
// ============================================================================
`default_nettype none

package ebec_pkg;

    // Width of the press, click and activity timers.
    localparam int TIMER_WIDTH = 16;
    localparam int THRESH_WIDTH = 16;
    localparam int CMP_WIDTH = (TIMER_WIDTH > THRESH_WIDTH) ? TIMER_WIDTH : THRESH_WIDTH;

    localparam int VALUE_WIDTH = 10;
    localparam int STEP_WIDTH = 7;
    localparam int DELTA_WIDTH = 4;
    localparam int EVENT_WIDTH = 3;
    localparam int TALLY_WIDTH = 3;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 16;

    // Reset values of the configuration registers.
    localparam logic [THRESH_WIDTH-1:0] LONG_PRESS_RESET = THRESH_WIDTH'(600);
    localparam logic [THRESH_WIDTH-1:0] MULTICLICK_RESET = THRESH_WIDTH'(400);
    localparam logic [THRESH_WIDTH-1:0] INACTIVITY_RESET = THRESH_WIDTH'(30000);
    localparam logic [VALUE_WIDTH-1:0] VALUE_MAX_RESET = VALUE_WIDTH'(100);
    localparam logic [STEP_WIDTH-1:0] STEP_SIZE_RESET = STEP_WIDTH'(1);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LONG_PRESS = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MULTICLICK = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INACTIVITY = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_VALUE_MAX = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STEP_SIZE = 3'd4;

    // Edit event codes.
    localparam logic [EVENT_WIDTH-1:0] EV_NONE = 3'd0;
    localparam logic [EVENT_WIDTH-1:0] EV_STARTED = 3'd1;
    localparam logic [EVENT_WIDTH-1:0] EV_CONFIRMED = 3'd2;
    localparam logic [EVENT_WIDTH-1:0] EV_CANCELLED = 3'd3;
    localparam logic [EVENT_WIDTH-1:0] EV_TIMEOUT = 3'd4;

    localparam logic [TALLY_WIDTH-1:0] TALLY_MAX = 3'd7;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

    typedef struct packed {
        logic [THRESH_WIDTH-1:0] long_press_ticks;
        logic [THRESH_WIDTH-1:0] multiclick_ticks;
        logic [THRESH_WIDTH-1:0] inactivity_ticks;
        logic [VALUE_WIDTH-1:0] value_max;
        logic [STEP_WIDTH-1:0] step_size;
    } cfg_t;

    typedef struct packed {
        logic prev_button;
        logic [TALLY_WIDTH-1:0] click_tally;
        logic [TIMER_WIDTH-1:0] press_elapsed;
        logic [TIMER_WIDTH-1:0] since_click;
        logic [TIMER_WIDTH-1:0] since_activity;
        logic edit_active;
        logic [VALUE_WIDTH-1:0] value_tenths;
    } state_t;

    typedef struct packed {
        logic editing;
        logic [VALUE_WIDTH-1:0] edited_value;
        logic [EVENT_WIDTH-1:0] edit_event;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/ebec_ifs.sv
// ============================================================================
// ebec_ifs - item channels of the encoder/button edit controller
// Tick input channel and result output channel, valid/ready handshake.
// ============================================================================
`default_nettype none

interface ebec_in_if;
    logic valid;
    logic ready;
    logic button_level;
    logic signed [ebec_pkg::DELTA_WIDTH-1:0] encoder_delta;

    modport source (output valid, output button_level, output encoder_delta, input ready);
    modport sink (input valid, input button_level, input encoder_delta, output ready);
endinterface

interface ebec_out_if;
    logic valid;
    logic ready;
    logic editing;
    logic [ebec_pkg::VALUE_WIDTH-1:0] edited_value;
    logic [ebec_pkg::EVENT_WIDTH-1:0] edit_event;

    modport source (output valid, output editing, output edited_value, output edit_event,
                    input ready);
    modport sink (input valid, input editing, input edited_value, input edit_event,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/ebec_cfg.sv
// ============================================================================
// ebec_cfg - configuration registers
// Holds the five threshold and scaling registers; writes beyond them are ignored.
// ============================================================================
`default_nettype none

module ebec_cfg (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [ebec_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [ebec_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    output ebec_pkg::cfg_t                            cfg
);
    import ebec_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LONG_PRESS: cfg_next.long_press_ticks = cfg_wdata[THRESH_WIDTH-1:0];
                CFG_MULTICLICK: cfg_next.multiclick_ticks = cfg_wdata[THRESH_WIDTH-1:0];
                CFG_INACTIVITY: cfg_next.inactivity_ticks = cfg_wdata[THRESH_WIDTH-1:0];
                CFG_VALUE_MAX:  cfg_next.value_max = cfg_wdata[VALUE_WIDTH-1:0];
                CFG_STEP_SIZE:  cfg_next.step_size = cfg_wdata[STEP_WIDTH-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks <= LONG_PRESS_RESET;
            cfg_reg.multiclick_ticks <= MULTICLICK_RESET;
            cfg_reg.inactivity_ticks <= INACTIVITY_RESET;
            cfg_reg.value_max <= VALUE_MAX_RESET;
            cfg_reg.step_size <= STEP_SIZE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/ebec_step.sv
// ============================================================================
// ebec_step - one tick of the edit controller
// Timers, encoder update with clamp, button edges, click decode and timeout.
// ============================================================================
`default_nettype none

module ebec_step (
    input  wire ebec_pkg::cfg_t                           cfg,
    input  wire ebec_pkg::state_t                         state,
    input  wire logic                                     button_level,
    input  wire logic signed [ebec_pkg::DELTA_WIDTH-1:0]  encoder_delta,
    output ebec_pkg::state_t                              state_out,
    output ebec_pkg::result_t                             result
);
    import ebec_pkg::*;

    localparam int SUM_WIDTH = VALUE_WIDTH + 2;

    logic signed [SUM_WIDTH-1:0] delta_x;
    logic signed [SUM_WIDTH-1:0] step_x;
    logic signed [SUM_WIDTH-1:0] product;
    logic signed [SUM_WIDTH-1:0] sum;
    logic [VALUE_WIDTH-1:0] clamped;

    // Encoder arithmetic: value plus delta times step, clamped to 0..value_max.
    assign delta_x = SUM_WIDTH'(encoder_delta);
    assign step_x = signed'(SUM_WIDTH'(cfg.step_size));
    assign product = delta_x * step_x;
    assign sum = signed'(SUM_WIDTH'(state.value_tenths)) + product;

    always_comb
    begin
        if (sum < 0)
            clamped = '0;
        else if (sum > signed'(SUM_WIDTH'(cfg.value_max)))
            clamped = cfg.value_max;
        else
            clamped = sum[VALUE_WIDTH-1:0];
    end

    function automatic logic [TIMER_WIDTH-1:0] tmr_inc(input logic [TIMER_WIDTH-1:0] t);
        return (t == TIMER_MAX) ? t : t + TIMER_WIDTH'(1);
    endfunction

    always_comb
    begin
        logic [EVENT_WIDTH-1:0] ev;
        state_t s;

        s = state;
        ev = EV_NONE;
        s.press_elapsed = tmr_inc(state.press_elapsed);
        s.since_click = tmr_inc(state.since_click);
        s.since_activity = tmr_inc(state.since_activity);

        if (encoder_delta != '0)
        begin
            s.since_activity = '0;
            if (s.edit_active)
                s.value_tenths = clamped;
        end

        if (state.prev_button && !button_level)
        begin
            s.press_elapsed = '0;
        end
        else if (!state.prev_button && button_level)
        begin
            if (CMP_WIDTH'(s.press_elapsed) >= CMP_WIDTH'(cfg.long_press_ticks))
            begin
                s.click_tally = '0;
                if (s.edit_active)
                begin
                    s.edit_active = 1'b0;
                    ev = EV_CANCELLED;
                end
            end
            else
            begin
                if (s.click_tally != TALLY_MAX)
                    s.click_tally = s.click_tally + TALLY_WIDTH'(1);
                s.since_click = '0;
            end
            s.since_activity = '0;
        end
        s.prev_button = button_level;

        // Click decode once the multiclick window has passed.
        if (s.click_tally != '0
            && CMP_WIDTH'(s.since_click) > CMP_WIDTH'(cfg.multiclick_ticks))
        begin
            if (s.click_tally == TALLY_WIDTH'(1))
            begin
                ev = s.edit_active ? EV_CONFIRMED : EV_STARTED;
                s.edit_active = !s.edit_active;
            end
            else if (s.click_tally == TALLY_WIDTH'(2))
            begin
                ev = s.edit_active ? EV_CANCELLED : EV_STARTED;
                s.edit_active = !s.edit_active;
            end
            s.click_tally = '0;
            s.since_activity = '0;
        end

        if (s.edit_active
            && CMP_WIDTH'(s.since_activity) > CMP_WIDTH'(cfg.inactivity_ticks))
        begin
            s.edit_active = 1'b0;
            ev = EV_TIMEOUT;
            s.since_activity = '0;
        end

        state_out = s;
        result.editing = s.edit_active;
        result.edited_value = s.value_tenths;
        result.edit_event = ev;
    end

endmodule

`default_nettype wire

>>> rtl/encoder_button_edit_controller_top.sv
// ============================================================================
// encoder_button_edit_controller_top - encoder and push-button edit controller
// Turns millisecond ticks of button level and encoder movement into edit events.
// ============================================================================
// Usage: each item on in_ch is one millisecond tick carrying the sampled
// button line (low when pressed) and the signed encoder change for that tick.
// Every tick produces exactly one result item on out_ch: the edit flag, the
// edited value in tenths and an event code (started, confirmed, cancelled or
// confirmed by timeout).
// An accepted item is held in an input register; the tick logic evaluates it
// combinationally and the result register is loaded once it is free or its
// item is being taken, and the result item is then offered from there.
// Throughput is one item per cycle while the receiver is ready: the state update
// is a single pass of short logic between the input and result registers.
// If the receiver stalls, the result register holds its item and the input
// register holds the next one; in_ch.ready then drops until the result moves.
// Reset clears both registers' valid flags, returns the state to released
// button, no tally, zero timers, no edit and value zero, and loads the
// configuration registers with their default values.
// Configuration is written through cfg_we, cfg_index and cfg_wdata and must
// only change while no item is in flight.
// ============================================================================
`default_nettype none

module encoder_button_edit_controller_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    ebec_in_if.sink                                   in_ch,
    ebec_out_if.source                                out_ch,
    input  wire logic                                 cfg_we,
    input  wire logic [ebec_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [ebec_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);
    import ebec_pkg::*;

    cfg_t cfg;
    state_t state_reg;
    state_t state_next;
    result_t res_next;
    result_t res_reg;
    logic res_valid_reg;
    logic in_valid_reg;
    logic in_button_reg;
    logic signed [DELTA_WIDTH-1:0] in_delta_reg;
    logic advance;

    ebec_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ebec_step u_step (
        .cfg           (cfg),
        .state         (state_reg),
        .button_level  (in_button_reg),
        .encoder_delta (in_delta_reg),
        .state_out     (state_next),
        .result        (res_next)
    );

    // The held tick is processed whenever the result register is free or
    // its item is being taken in this cycle.
    assign advance = in_valid_reg && (!res_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg.prev_button <= 1'b1;
            state_reg.click_tally <= '0;
            state_reg.press_elapsed <= '0;
            state_reg.since_click <= '0;
            state_reg.since_activity <= '0;
            state_reg.edit_active <= 1'b0;
            state_reg.value_tenths <= '0;
        end
        else
        begin
            if (in_ch.ready)
                in_valid_reg <= in_ch.valid;
            if (advance)
                state_reg <= state_next;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (out_ch.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_button_reg <= in_ch.button_level;
            in_delta_reg <= in_ch.encoder_delta;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign out_ch.valid = res_valid_reg;
    assign out_ch.editing = res_reg.editing;
    assign out_ch.edited_value = res_reg.edited_value;
    assign out_ch.edit_event = res_reg.edit_event;

`ifndef ASSERT_OFF
    // A started edit is always reported with the edit flag set.
    a_started_editing: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.edit_event == EV_STARTED) |-> res_reg.editing)
        else $error("started event without edit flag");

    // Ending events always leave the edit flag clear.
    a_end_not_editing: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.edit_event == EV_CONFIRMED
            || res_reg.edit_event == EV_CANCELLED || res_reg.edit_event == EV_TIMEOUT))
        |-> !res_reg.editing)
        else $error("ending event with edit flag set");

    // A held tick is not dropped while the result side is stalled.
    a_held_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending tick lost");

    // The controller state moves only when a tick is processed.
    a_state_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a tick");

    // Event codes stay within the defined set.
    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.edit_event <= EV_TIMEOUT))
        else $error("undefined event code");
`endif

endmodule

`default_nettype wire

>>> tb/ebec_scoreboard_pkg.sv
// ============================================================================
// ebec_scoreboard_pkg - tick prediction and result checking for the testbench
// Tracks the controller state tick by tick and checks result items in order.
// ============================================================================
`default_nettype none

package ebec_scoreboard_pkg;
    import ebec_pkg::*;

    class edit_scoreboard;
        cfg_t        cfg;
        state_t      st;
        result_t     results_due[$];
        int unsigned errors;

        function new();
            cfg.long_press_ticks = LONG_PRESS_RESET;
            cfg.multiclick_ticks = MULTICLICK_RESET;
            cfg.inactivity_ticks = INACTIVITY_RESET;
            cfg.value_max = VALUE_MAX_RESET;
            cfg.step_size = STEP_SIZE_RESET;
            st = '0;
            st.prev_button = 1'b1;
            errors = 0;
        endfunction

        // Narrow registers keep only their low bits; unused indexes do nothing.
        function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
                                logic [CFG_DATA_WIDTH-1:0] data);
            case (idx)
                CFG_LONG_PRESS: cfg.long_press_ticks = data[THRESH_WIDTH-1:0];
                CFG_MULTICLICK: cfg.multiclick_ticks = data[THRESH_WIDTH-1:0];
                CFG_INACTIVITY: cfg.inactivity_ticks = data[THRESH_WIDTH-1:0];
                CFG_VALUE_MAX:  cfg.value_max = data[VALUE_WIDTH-1:0];
                CFG_STEP_SIZE:  cfg.step_size = data[STEP_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        function logic [TIMER_WIDTH-1:0] bump(logic [TIMER_WIDTH-1:0] t);
            return (t == TIMER_MAX) ? t : t + 1'b1;
        endfunction

        // Advances the state by one tick and queues the result it should give.
        function void note_tick(logic btn, logic signed [DELTA_WIDTH-1:0] delta);
            int                     sum;
            logic [EVENT_WIDTH-1:0] ev;
            result_t                r;
            ev = EV_NONE;
            st.press_elapsed = bump(st.press_elapsed);
            st.since_click = bump(st.since_click);
            st.since_activity = bump(st.since_activity);

            if (delta != 0)
            begin
                st.since_activity = '0;
                if (st.edit_active)
                begin
                    sum = int'(st.value_tenths) + int'(delta) * int'(cfg.step_size);
                    if (sum < 0)
                        sum = 0;
                    if (sum > int'(cfg.value_max))
                        sum = int'(cfg.value_max);
                    st.value_tenths = VALUE_WIDTH'(sum);
                end
            end

            if (st.prev_button && !btn)
            begin
                st.press_elapsed = '0;
            end
            else if (!st.prev_button && btn)
            begin
                if (st.press_elapsed >= cfg.long_press_ticks)
                begin
                    st.click_tally = '0;
                    if (st.edit_active)
                    begin
                        st.edit_active = 1'b0;
                        ev = EV_CANCELLED;
                    end
                end
                else
                begin
                    if (st.click_tally != TALLY_MAX)
                        st.click_tally = st.click_tally + 1'b1;
                    st.since_click = '0;
                end
                st.since_activity = '0;
            end
            st.prev_button = btn;

            if (st.click_tally != 0 && st.since_click > cfg.multiclick_ticks)
            begin
                if (st.click_tally == 1)
                begin
                    ev = st.edit_active ? EV_CONFIRMED : EV_STARTED;
                    st.edit_active = !st.edit_active;
                end
                else if (st.click_tally == 2)
                begin
                    ev = st.edit_active ? EV_CANCELLED : EV_STARTED;
                    st.edit_active = !st.edit_active;
                end
                st.click_tally = '0;
                st.since_activity = '0;
            end

            if (st.edit_active && st.since_activity > cfg.inactivity_ticks)
            begin
                st.edit_active = 1'b0;
                ev = EV_TIMEOUT;
                st.since_activity = '0;
            end

            r.editing = st.edit_active;
            r.edited_value = st.value_tenths;
            r.edit_event = ev;
            results_due.push_back(r);
        endfunction

        function void complain(string what, int want, int got);
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (results_due.size() == 0)
            begin
                errors++;
                $display("%0t: result item with none due: expected none, actual %0d/%0d/%0d",
                         $time, got.editing, got.edited_value, got.edit_event);
                return;
            end
            want = results_due.pop_front();
            if (got.editing !== want.editing)
                complain("editing", int'(want.editing), int'(got.editing));
            if (got.edited_value !== want.edited_value)
                complain("edited_value", int'(want.edited_value), int'(got.edited_value));
            if (got.edit_event !== want.edit_event)
                complain("edit_event", int'(want.edit_event), int'(got.edit_event));
        endfunction
    endclass

endpackage

`default_nettype wire

>>> tb/encoder_button_edit_controller_top_test.sv
// ============================================================================
// encoder_button_edit_controller_top_test - testbench of the edit controller
// Drives millisecond ticks of button level and encoder movement through the
// valid/ready channels, predicts every result item tick by tick and checks
// the results in order, across several register settings and idle patterns.
// ============================================================================
`default_nettype none

module encoder_button_edit_controller_top_test;
    import ebec_pkg::*;
    import ebec_scoreboard_pkg::*;

    // Per-item idle draw of either side, in cycles.
    localparam int GAP_MAX = 15;
    // Length of the one deliberate receiver hold-off that backs up the block.
    localparam int LONG_STALL_CYCLES = 64;
    // Cycles without any accepted item before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 110;
    // A press far longer than any of the random long-press limits.
    localparam int LONG_HOLD = 40;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_wdata;

    ebec_in_if  in_ch();
    ebec_out_if out_ch();

    encoder_button_edit_controller_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    edit_scoreboard sb;

    // Controls shared between the sending and receiving processes.
    bit sender_gaps;
    bit receiver_gaps;
    bit long_stall_req;
    int ticks_sent;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Sending side
    // ------------------------------------------------------------------------

    // Offers one tick after a random pause and returns at the edge at which
    // it is accepted. Nothing here lowers valid at the end, so the caller
    // either offers the next tick in the same time step or flushes.
    task automatic send_tick(input logic btn, input logic signed [DELTA_WIDTH-1:0] delta);
        int gap;
        gap = sender_gaps ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.button_level <= btn;
        in_ch.encoder_delta <= delta;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_tick(btn, delta);
        ticks_sent++;
    endtask

    // Holds the button at one level for n ticks. With jitter, about a
    // quarter of the ticks also carry a random encoder movement.
    task automatic hold_level(input logic btn, input int n, input bit jitter);
        logic signed [DELTA_WIDTH-1:0] d;
        repeat (n)
        begin
            d = (jitter && $urandom_range(0, 3) == 0) ? DELTA_WIDTH'($urandom) : '0;
            send_tick(btn, d);
        end
    endtask

    // Stops offering and waits until every predicted result has been
    // received. Each tick gives exactly one result, so the block is idle
    // once nothing is due; the extra wait merely lets it settle.
    task automatic flush_results();
        in_ch.valid <= 1'b0;
        while (sb.results_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Writes all five registers while the block is idle. The narrow
    // registers get random upper bits, which the block must drop. With junk
    // set, a write to an unused index follows and must change nothing.
    task automatic apply_config(input cfg_t c, input bit junk);
        flush_results();
        put_reg(CFG_LONG_PRESS, c.long_press_ticks);
        put_reg(CFG_MULTICLICK, c.multiclick_ticks);
        put_reg(CFG_INACTIVITY, c.inactivity_ticks);
        put_reg(CFG_VALUE_MAX, {6'($urandom), c.value_max});
        put_reg(CFG_STEP_SIZE, {9'($urandom), c.step_size});
        if (junk)
            put_reg(CFG_INDEX_WIDTH'(CFG_STEP_SIZE + 1 + $urandom_range(0, 2)),
                    CFG_DATA_WIDTH'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Short thresholds, so that clicks, long presses and timeouts all fit
    // into a handful of ticks. Steps are mostly small, sometimes large.
    function automatic cfg_t small_cfg();
        cfg_t c;
        c.long_press_ticks = THRESH_WIDTH'($urandom_range(2, 8));
        c.multiclick_ticks = THRESH_WIDTH'($urandom_range(1, 6));
        c.inactivity_ticks = THRESH_WIDTH'($urandom_range(6, 30));
        c.value_max = VALUE_WIDTH'($urandom_range(0, 1023));
        c.step_size = STEP_WIDTH'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 100)
                                                               : $urandom_range(1, 9));
        return c;
    endfunction

    // One user gesture, sized from the current thresholds. Most of them are
    // well-formed: click groups that are then decoded, long presses, turns
    // of the encoder and idle spells long enough for the timeout. The rest
    // is noise on both fields and short pauses.
    task automatic play_gesture();
        int lp;
        int mc;
        int ia;
        int n;
        lp = sb.cfg.long_press_ticks;
        mc = sb.cfg.multiclick_ticks;
        ia = sb.cfg.inactivity_ticks;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    hold_level(1'b0, $urandom_range(1, (lp > 1) ? lp - 1 : 1), 1'b1);
                    hold_level(1'b1, 1 + $urandom_range(0, mc - 1), 1'b1);
                end
                hold_level(1'b1, mc + $urandom_range(1, 3), 1'b0);
            end
            4:
            begin
                hold_level(1'b0, lp + $urandom_range(0, 2), 1'b1);
                hold_level(1'b1, 1, 1'b0);
            end
            5, 6:
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    send_tick(1'b1, DELTA_WIDTH'($urandom));
            end
            7:
                hold_level(1'b1, ia + $urandom_range(1, 2), 1'b0);
            8:
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    send_tick(1'($urandom), DELTA_WIDTH'($urandom));
            end
            default:
                hold_level(1'b1, $urandom_range(1, 4), 1'b0);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        cfg_t c;
        int   target;
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.button_level = 1'b1;
        in_ch.encoder_delta = '0;
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
        long_stall_req = 1'b0;
        ticks_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Under the reset settings the encoder extremes are
        // offered while not editing, so they must leave the value alone,
        // and a short press leaves one click in the tally.
        send_tick(1'b1, DELTA_WIDTH'(7));
        send_tick(1'b0, DELTA_WIDTH'(-8));
        send_tick(1'b0, '0);
        send_tick(1'b1, DELTA_WIDTH'(-1));

        // Tight thresholds, a low ceiling and a coarse step. The click left
        // over from above joins the next one, so the pair starts an edit.
        c.long_press_ticks = THRESH_WIDTH'(3);
        c.multiclick_ticks = THRESH_WIDTH'(1);
        c.inactivity_ticks = THRESH_WIDTH'(4);
        c.value_max = VALUE_WIDTH'(20);
        c.step_size = STEP_WIDTH'(7);
        apply_config(c, 1'b1);
        send_tick(1'b0, '0);
        send_tick(1'b1, '0);
        send_tick(1'b1, '0);
        send_tick(1'b1, '0);
        // Clamp at the ceiling, clamp at zero, then an ordinary step.
        send_tick(1'b1, DELTA_WIDTH'(7));
        send_tick(1'b1, DELTA_WIDTH'(-8));
        send_tick(1'b1, DELTA_WIDTH'(1));
        // Sitting still past the inactivity limit confirms by timeout.
        hold_level(1'b1, 6, 1'b0);
        // A single click starts a new edit...
        send_tick(1'b0, '0);
        hold_level(1'b1, 3, 1'b0);
        // ...and a press held for exactly the long-press time cancels it.
        hold_level(1'b0, 3, 1'b0);
        send_tick(1'b1, '0);

        // Random part, one register setting per phase. The first phase sits
        // at the lowest thresholds, the next two raise the value with a big
        // step and then pull the ceiling below it, then a zero ceiling and a
        // zero step. Phase five backs the block up with a long receiver
        // hold-off against a sender without pauses, phase six pauses the
        // sender until all results are in, and phase seven runs with no
        // idling on either side.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            c = small_cfg();
            case (p)
                0:
                begin
                    c.long_press_ticks = THRESH_WIDTH'(1);
                    c.multiclick_ticks = THRESH_WIDTH'(1);
                    c.inactivity_ticks = THRESH_WIDTH'(1);
                    c.value_max = VALUE_WIDTH'(1023);
                    c.step_size = STEP_WIDTH'(100);
                end
                1:
                begin
                    c.value_max = VALUE_WIDTH'(1023);
                    c.step_size = STEP_WIDTH'(100);
                end
                2: c.value_max = VALUE_WIDTH'($urandom_range(0, 60));
                3: c.value_max = '0;
                4: c.step_size = '0;
                default: ;
            endcase
            sender_gaps = (p != 5 && p != 7);
            receiver_gaps = (p != 7);
            apply_config(c, p == 3);
            if (p == 5)
                long_stall_req = 1'b1;
            target = ticks_sent + PHASE_ITEMS;
            while (ticks_sent < target)
            begin
                play_gesture();
                if (p == 6 && ticks_sent >= target - PHASE_ITEMS / 2 && sender_gaps)
                begin
                    flush_results();
                    sender_gaps = 1'b0;
                end
            end
        end

        // Limits at the timer ceiling: open an edit with an inactivity limit
        // that can never be exceeded, then raise the press and click limits
        // to the ceiling as well. A long press now counts as a click, and
        // the tally is never decoded, so the edit stays open throughout.
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        c = small_cfg();
        c.long_press_ticks = THRESH_WIDTH'(8);
        c.multiclick_ticks = THRESH_WIDTH'(2);
        c.inactivity_ticks = TIMER_MAX;
        apply_config(c, 1'b0);
        for (int k = 0; k < 4 && !sb.st.edit_active; k++)
        begin
            hold_level(1'b0, 2, 1'b0);
            hold_level(1'b1, 5, 1'b0);
        end
        c.long_press_ticks = TIMER_MAX;
        c.multiclick_ticks = TIMER_MAX;
        apply_config(c, 1'b0);
        hold_level(1'b0, LONG_HOLD, 1'b0);
        send_tick(1'b1, '0);
        hold_level(1'b0, 3, 1'b0);
        hold_level(1'b1, 20, 1'b1);

        flush_results();
        repeat (5) @(posedge clk);
        if (sb.errors == 0)
            $display("encoder_button_edit_controller_top verification clean");
        else
            $display("encoder_button_edit_controller_top verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiving side: stalls at random before each result item, or once for
    // a long stretch when asked, and checks every item it takes.
    // ------------------------------------------------------------------------
    initial
    begin
        int      hold;
        result_t got;
        out_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            hold = long_stall_req ? LONG_STALL_CYCLES
                                  : (receiver_gaps ? $urandom_range(0, GAP_MAX) : 0);
            long_stall_req = 1'b0;
            if (hold > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            got.editing = out_ch.editing;
            got.edited_value = out_ch.edited_value;
            got.edit_event = out_ch.edit_event;
            sb.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any accepted item on either channel counts as progress.
    // ------------------------------------------------------------------------
    initial
        quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no item accepted for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("encoder_button_edit_controller_top verification failed");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/ebec_pkg.sv
rtl/ebec_ifs.sv
rtl/ebec_cfg.sv
rtl/ebec_step.sv
rtl/encoder_button_edit_controller_top.sv
tb/ebec_scoreboard_pkg.sv
tb/encoder_button_edit_controller_top_test.sv
